@@ rtl/core/text_command_line_decoder_unit_defines.svh @@
// ----------------------------------------------------------------------------
// text command line decoder assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef TEXT_COMMAND_LINE_DECODER_UNIT_DEFINES_SVH
`define TEXT_COMMAND_LINE_DECODER_UNIT_DEFINES_SVH

// same-cycle implication
`define TCLD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCLD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tcld_pkg.sv @@
// ----------------------------------------------------------------------------
// tcld_pkg
// shared constants, types and helper functions of the command line decoder
// ----------------------------------------------------------------------------
package tcld_pkg;

  localparam int LINE_MAX = 64;
  localparam int IDX_W    = $clog2(LINE_MAX);
  localparam int LEN_W    = $clog2(LINE_MAX + 1);
  localparam int ADDR_W   = IDX_W + 1;
  localparam int MEM_DEPTH = 2 * LINE_MAX;

  // character codes
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_CASE    = 8'h20;
  localparam logic [7:0] CH_LOWER_O = 8'h6F;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;

  typedef enum logic [3:0] {
    CODE_UNKNOWN  = 4'd0,
    CODE_HELP     = 4'd1,
    CODE_PING     = 4'd2,
    CODE_STATUS   = 4'd3,
    CODE_DISTANCE = 4'd4,
    CODE_STOP     = 4'd5,
    CODE_FORWARD  = 4'd6,
    CODE_BACKWARD = 4'd7,
    CODE_TURN     = 4'd8,
    CODE_SPEED    = 4'd9,
    CODE_AVOID    = 4'd10,
    CODE_DEBUG    = 4'd11
  } cmd_e;

  // keyword table, left aligned, padded to eight characters
  localparam int KW_NUM      = 14;
  localparam int KW_HELP     = 0;
  localparam int KW_PING     = 1;
  localparam int KW_STATUS   = 2;
  localparam int KW_DISTANCE = 3;
  localparam int KW_STOP     = 4;
  localparam int KW_S        = 5;
  localparam int KW_FORWARD  = 6;
  localparam int KW_F        = 7;
  localparam int KW_BACKWARD = 8;
  localparam int KW_B        = 9;
  localparam int KW_TURN     = 10;
  localparam int KW_SPEED    = 11;
  localparam int KW_AVOID    = 12;
  localparam int KW_DEBUG    = 13;

  localparam logic [63:0] KW_STR [KW_NUM] = '{
    "help____", "ping____", "status__", "distance", "stop____", "s_______",
    "forward_", "f_______", "backward", "b_______", "turn____", "speed___",
    "avoid___", "debug___"
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd4, 4'd4, 4'd6, 4'd8, 4'd4, 4'd1, 4'd7, 4'd1, 4'd8, 4'd1, 4'd4, 4'd5,
    4'd5, 4'd5
  };

  localparam logic [31:0] NUM_NEG_LIM = 32'h8000_0000;
  localparam logic [31:0] NUM_POS_LIM = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    NUM_LEAD  = 2'd0,
    NUM_DIGIT = 2'd1,
    NUM_DONE  = 2'd2
  } num_phase_e;

  typedef struct packed {
    num_phase_e  phase;
    logic        neg;
    logic [31:0] mag;
  } num_t;

  localparam num_t NUM_INIT = '{phase: NUM_LEAD, neg: 1'b0, mag: 32'd0};

  // stored character: whitespace mark and lowercased byte
  typedef struct packed {
    logic       ws;
    logic [7:0] ch;
  } char_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    char_t             data;
  } wr_t;

  // one character into the atol-like parser
  function automatic num_t num_step(num_t n, logic [7:0] c, logic ws);
    num_t        r;
    logic [35:0] acc;
    logic [31:0] sat;
    logic        dig;
    r   = n;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    acc = {4'd0, n.mag} * 36'd10 + {32'd0, c[3:0]};
    sat = (acc > {4'd0, NUM_NEG_LIM}) ? NUM_NEG_LIM : acc[31:0];
    case (n.phase)
      NUM_LEAD: begin
        if (ws) begin
          r.phase = NUM_LEAD;
        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
          r.neg   = (c == CH_MINUS);
          r.phase = NUM_DIGIT;
        end else if (dig) begin
          r.mag   = sat;
          r.phase = NUM_DIGIT;
        end else begin
          r.phase = NUM_DONE;
        end
      end
      NUM_DIGIT: begin
        if (dig) begin
          r.mag = sat;
        end else begin
          r.phase = NUM_DONE;
        end
      end
      default: r = n;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] num_final(num_t n);
    logic [31:0] v;
    if (n.neg) begin
      v = 32'd0 - n.mag;
    end else begin
      v = (n.mag > NUM_POS_LIM) ? NUM_POS_LIM : n.mag;
    end
    return $signed(v);
  endfunction

endpackage

@@ rtl/core/text_command_line_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// text_command_line_decoder_unit
// serial text line buffer with keyword and number decoding
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         one raw character byte per item
//  m_axis    out        command code, two numbers, on flag per decoded line
//
// a character is accepted when offered unless input stalls; a line is written to one of two banks
// a finished line passes an idle state, a trim scan, a decode of the trimmed
//   characters and an output state; the scan and the decode both read the bank
//   through the single read port
// input stalls only while both banks hold lines not yet handed over
// reset empties the line count and the queue; bank contents stay undefined
// a stalled result holds in the output registers until taken
module text_command_line_decoder_unit import tcld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // [3:0] command_code, [35:4] first_number,
                                        // [67:36] second_number, [68] on_flag,
                                        // [71:69] zero
);

  logic               q_full, q_valid, push, pop;
  logic [LEN_W-1:0]   push_len, head_len;
  wr_t                wr;
  logic [3:0]         code;
  logic signed [31:0] first_num, second_num;
  logic               flag;

  // front: classify and buffer characters
  tcld_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_char_i  (s_axis_tdata_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_len_o (push_len),
    .wr_o       (wr)
  );

  // finished lines waiting for the decoder
  tcld_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_len_i (push_len),
    .pop_i      (pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_len)
  );

  // back: trim, decode and present one line at a time
  tcld_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .q_valid_i    (q_valid),
    .q_len_i      (head_len),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_code_o   (code),
    .out_first_o  (first_num),
    .out_second_o (second_num),
    .out_flag_o   (flag)
  );

  assign m_axis_tdata_o = {3'b000, flag, second_num, first_num, code};

endmodule

@@ rtl/core/tcld_front.sv @@
// ----------------------------------------------------------------------------
// tcld_front
// accepts characters, classifies them and fills the current line bank
// ----------------------------------------------------------------------------
module tcld_front import tcld_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_char_i,
  input  logic             q_full_i,
  output logic             push_o,
  output logic [LEN_W-1:0] push_len_o,
  output wr_t              wr_o
);

  logic [LEN_W-1:0] len_q, len_d;
  logic             bank_q, bank_d;
  logic             acc, term, ws;
  logic [7:0]       lc;

  assign in_ready_o = ~q_full_i;
  assign acc        = in_valid_i & in_ready_o;
  assign term       = (in_char_i == CH_LF) || (in_char_i == CH_CR);
  assign ws         = (in_char_i == CH_SPACE) ||
                      ((in_char_i >= CH_TAB) && (in_char_i <= CH_CR));
  assign lc         = ((in_char_i >= CH_UPPER_A) && (in_char_i <= CH_UPPER_Z)) ?
                      (in_char_i + CH_CASE) : in_char_i;

  always_comb begin
    len_d      = len_q;
    bank_d     = bank_q;
    push_o     = 1'b0;
    push_len_o = len_q;
    wr_o.en    = 1'b0;
    wr_o.addr  = {bank_q, len_q[IDX_W-1:0]};
    wr_o.data  = '{ws: ws, ch: lc};
    if (acc) begin
      if (term) begin
        if (len_q != '0) begin
          push_o = 1'b1;
          len_d  = '0;
          bank_d = ~bank_q;
        end
      end else if (len_q < LEN_W'(LINE_MAX)) begin
        wr_o.en = 1'b1;
        len_d   = len_q + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      bank_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      bank_q <= bank_d;
    end
  end

endmodule

@@ rtl/core/tcld_queue.sv @@
// ----------------------------------------------------------------------------
// tcld_queue
// two-entry queue of finished line lengths, one per line bank
// ----------------------------------------------------------------------------
module tcld_queue import tcld_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [LEN_W-1:0] push_len_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [LEN_W-1:0] head_o
);

  logic [LEN_W-1:0] ent_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= push_len_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

@@ rtl/core/tcld_back.sv @@
// ----------------------------------------------------------------------------
// tcld_back
// holds the line banks, trims and decodes a queued line, presents the result
// ----------------------------------------------------------------------------
`include "text_command_line_decoder_unit_defines.svh"

module tcld_back import tcld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wr_t                wr_i,
  input  logic               q_valid_i,
  input  logic [LEN_W-1:0]   q_len_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         out_code_o,
  output logic signed [31:0] out_first_o,
  output logic signed [31:0] out_second_o,
  output logic               out_flag_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DEC, ST_OUT} state_e;

  char_t             mem [MEM_DEPTH];
  char_t             rdata_q;
  logic [ADDR_W-1:0] rd_addr;

  state_e           state_q;
  logic             rbank_q;
  logic [LEN_W-1:0] cnt_q, idx_q, s_q, e_q;
  logic             pend_q, found_q;

  // decoder state
  logic              inword_q, space_q, split_q, on_q, argsp_q;
  logic [3:0]        wpos_q;
  logic [1:0]        qpos_q;
  logic [KW_NUM-1:0] match_q;
  num_t              numw_q, numa_q, numb_q;

  logic              inword_d, space_d, split_d, on_d, argsp_d;
  logic [3:0]        wpos_d;
  logic [1:0]        qpos_d;
  logic [KW_NUM-1:0] match_d, wm;
  num_t              numw_d, numa_d, numb_d;

  cmd_e               code;
  logic signed [31:0] fa, fb;
  logic               flag;
  logic [LEN_W-1:0]   limit;

  assign rd_addr = {rbank_q, cnt_q[IDX_W-1:0]};
  assign limit   = (state_q == ST_SCAN) ? q_len_i : e_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[wr_i.addr] <= wr_i.data;
    rdata_q <= mem[rd_addr];
  end

  // one trimmed character into the decoder
  always_comb begin
    inword_d = inword_q;
    space_d  = space_q;
    split_d  = split_q;
    on_d     = on_q;
    argsp_d  = argsp_q;
    wpos_d   = wpos_q;
    qpos_d   = qpos_q;
    match_d  = match_q;
    numw_d   = numw_q;
    numa_d   = numa_q;
    numb_d   = numb_q;
    if (inword_q) begin
      if (rdata_q.ch == CH_SPACE) begin
        inword_d = 1'b0;
        space_d  = 1'b1;
      end else begin
        for (int k = 0; k < KW_NUM; k++) begin
          match_d[k] = match_q[k] && (wpos_q < KW_LEN[k]) &&
                       (rdata_q.ch == KW_STR[k][8*(7-int'(wpos_q[2:0])) +: 8]);
        end
        if (wpos_q != 4'hF) wpos_d = wpos_q + 4'd1;
      end
    end else begin
      on_d = on_q && (((qpos_q == 2'd0) && (rdata_q.ch == CH_LOWER_O)) ||
                      ((qpos_q == 2'd1) && (rdata_q.ch == CH_LOWER_N)));
      if (qpos_q != 2'd3) qpos_d = qpos_q + 2'd1;
      if (rdata_q.ch == CH_SPACE) argsp_d = 1'b1;
      numw_d = num_step(numw_q, rdata_q.ch, rdata_q.ws);
      // the pair splits only at the first space of the argument
      if (split_q) begin
        numb_d = num_step(numb_q, rdata_q.ch, rdata_q.ws);
      end else if ((rdata_q.ch == CH_SPACE) && (qpos_q != 2'd0) && !argsp_q) begin
        split_d = 1'b1;
      end else begin
        numa_d = num_step(numa_q, rdata_q.ch, rdata_q.ws);
      end
    end
  end

  // final selection from the decoder state
  always_comb begin
    for (int k = 0; k < KW_NUM; k++) begin
      wm[k] = match_q[k] && (wpos_q == KW_LEN[k]);
    end
    code = CODE_UNKNOWN;
    fa   = '0;
    fb   = '0;
    flag = 1'b0;
    if (!space_q) begin
      if (wm[KW_HELP])                      code = CODE_HELP;
      else if (wm[KW_PING])                 code = CODE_PING;
      else if (wm[KW_STATUS])               code = CODE_STATUS;
      else if (wm[KW_DISTANCE])             code = CODE_DISTANCE;
      else if (wm[KW_STOP] || wm[KW_S])     code = CODE_STOP;
      else if (wm[KW_FORWARD] || wm[KW_F])  code = CODE_FORWARD;
      else if (wm[KW_BACKWARD] || wm[KW_B]) code = CODE_BACKWARD;
    end else begin
      if (wm[KW_FORWARD] || wm[KW_F]) begin
        code = CODE_FORWARD;
        fa   = num_final(numa_q);
        fb   = num_final(numb_q);
      end else if (wm[KW_BACKWARD] || wm[KW_B]) begin
        code = CODE_BACKWARD;
        fa   = num_final(numa_q);
        fb   = num_final(numb_q);
      end else if (wm[KW_TURN]) begin
        code = CODE_TURN;
        fa   = num_final(numw_q);
      end else if (wm[KW_SPEED]) begin
        code = CODE_SPEED;
        fa   = num_final(numw_q);
      end else if (wm[KW_AVOID]) begin
        code = CODE_AVOID;
        flag = on_q && (qpos_q == 2'd2);
      end else if (wm[KW_DEBUG]) begin
        code = CODE_DEBUG;
        flag = on_q && (qpos_q == 2'd2);
      end
    end
  end

  assign pop_o       = (state_q == ST_OUT) && out_ready_i;
  assign out_valid_o = (state_q == ST_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rbank_q      <= 1'b0;
      cnt_q        <= '0;
      idx_q        <= '0;
      s_q          <= '0;
      e_q          <= '0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      inword_q     <= 1'b1;
      space_q      <= 1'b0;
      split_q      <= 1'b0;
      on_q         <= 1'b1;
      argsp_q      <= 1'b0;
      wpos_q       <= '0;
      qpos_q       <= '0;
      match_q      <= '1;
      numw_q       <= NUM_INIT;
      numa_q       <= NUM_INIT;
      numb_q       <= NUM_INIT;
      out_code_o   <= CODE_UNKNOWN;
      out_first_o  <= '0;
      out_second_o <= '0;
      out_flag_o   <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            cnt_q   <= '0;
            pend_q  <= 1'b0;
            found_q <= 1'b0;
            s_q     <= '0;
            e_q     <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN, ST_DEC: begin
          // address issue, data in the cycle after
          pend_q <= (cnt_q < limit);
          idx_q  <= cnt_q;
          if (cnt_q < limit) cnt_q <= cnt_q + LEN_W'(1);
          if (state_q == ST_SCAN) begin
            if (pend_q && !rdata_q.ws) begin
              if (!found_q) s_q <= idx_q;
              found_q <= 1'b1;
              e_q     <= idx_q + LEN_W'(1);
            end
            if (!pend_q && (cnt_q >= limit)) begin
              cnt_q    <= s_q;
              pend_q   <= 1'b0;
              inword_q <= 1'b1;
              space_q  <= 1'b0;
              split_q  <= 1'b0;
              on_q     <= 1'b1;
              argsp_q  <= 1'b0;
              wpos_q   <= '0;
              qpos_q   <= '0;
              match_q  <= '1;
              numw_q   <= NUM_INIT;
              numa_q   <= NUM_INIT;
              numb_q   <= NUM_INIT;
              state_q  <= ST_DEC;
            end
          end else begin
            if (pend_q) begin
              inword_q <= inword_d;
              space_q  <= space_d;
              split_q  <= split_d;
              on_q     <= on_d;
              argsp_q  <= argsp_d;
              wpos_q   <= wpos_d;
              qpos_q   <= qpos_d;
              match_q  <= match_d;
              numw_q   <= numw_d;
              numa_q   <= numa_d;
              numb_q   <= numb_d;
            end
            if (!pend_q && (cnt_q >= limit)) begin
              out_code_o   <= code;
              out_first_o  <= fa;
              out_second_o <= fb;
              out_flag_o   <= flag;
              state_q      <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            rbank_q <= ~rbank_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `TCLD_ASSERT_IMP(a_busy_has_line, state_q != ST_IDLE, q_valid_i,
    "line processing without a queued line")
  `TCLD_ASSERT_IMP(a_trim_order, found_q, s_q < e_q,
    "trim start not below trim end")
  `TCLD_ASSERT_IMP(a_dec_in_range, (state_q == ST_DEC) && pend_q,
    (idx_q >= s_q) && (idx_q < e_q), "decode read outside trimmed range")
  `TCLD_ASSERT_NXT(a_pop_to_idle, pop_o, state_q == ST_IDLE,
    "result handed over but decoder not back to idle")

endmodule

@@ dv/text_command_line_decoder_unit_tb.sv @@
// ----------------------------------------------------------------------------
// text_command_line_decoder_unit testbench
// streams characters into the decoder, predicts each decoded line in the
// bench and checks every result item field by field against the oldest one
// ----------------------------------------------------------------------------
module text_command_line_decoder_unit_tb;
  import tcld_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cmd_e               cmd;
    logic signed [31:0] num_a;
    logic signed [31:0] num_b;
    logic               on;
  } line_result_t;

  // line predictor plus queue of pending decoded lines
  class line_scoreboard;
    byte unsigned  line_q[$];
    line_result_t  pending_q[$];
    int            mismatches;

    function bit is_blank(byte unsigned c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function bit same_word(byte unsigned w[$], int lo, int hi, string s);
      if (hi - lo != s.len()) return 0;
      for (int k = 0; k < s.len(); k++)
        if (w[lo + k] != s[k]) return 0;
      return 1;
    endfunction

    function logic [31:0] atol_sat(byte unsigned w[$], int lo, int hi);
      int k;
      bit neg;
      longint unsigned mag;
      k = lo; neg = 0; mag = 0;
      while (k < hi && is_blank(w[k])) k++;
      if (k < hi && (w[k] == "+" || w[k] == "-")) begin
        neg = (w[k] == "-");
        k++;
      end
      while (k < hi && w[k] >= "0" && w[k] <= "9") begin
        mag = mag * 10 + (w[k] - "0");
        if (mag > 64'h8000_0000) mag = 64'h8000_0000;
        k++;
      end
      if (neg) return 32'd0 - mag[31:0];
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return mag[31:0];
    endfunction

    function int first_space(byte unsigned w[$], int lo, int hi);
      for (int k = lo; k < hi; k++) if (w[k] == 8'h20) return k;
      return hi;
    endfunction

    function void number_pair(byte unsigned w[$], int lo, int hi, ref line_result_t r);
      int sp;
      sp = first_space(w, lo, hi);
      if (sp < hi && sp > lo) begin
        r.num_a = atol_sat(w, lo, sp);
        r.num_b = atol_sat(w, sp + 1, hi);
      end else begin
        r.num_a = atol_sat(w, lo, hi);
      end
    endfunction

    function line_result_t decode_line();
      line_result_t r;
      byte unsigned w[$];
      int s, e, n, sp;
      r = '{CODE_UNKNOWN, 0, 0, 1'b0};
      s = 0; e = line_q.size();
      while (s < e && is_blank(line_q[s])) s++;
      while (e > s && is_blank(line_q[e-1])) e--;
      for (int k = s; k < e; k++)
        w.push_back((line_q[k] >= "A" && line_q[k] <= "Z") ? line_q[k] + 32 : line_q[k]);
      n = w.size();
      if (n == 0) return r;
      if (same_word(w, 0, n, "help")) r.cmd = CODE_HELP;
      else if (same_word(w, 0, n, "ping")) r.cmd = CODE_PING;
      else if (same_word(w, 0, n, "status")) r.cmd = CODE_STATUS;
      else if (same_word(w, 0, n, "distance")) r.cmd = CODE_DISTANCE;
      else if (same_word(w, 0, n, "stop") || same_word(w, 0, n, "s")) r.cmd = CODE_STOP;
      else if (same_word(w, 0, n, "forward") || same_word(w, 0, n, "f")) r.cmd = CODE_FORWARD;
      else if (same_word(w, 0, n, "backward") || same_word(w, 0, n, "b"))
        r.cmd = CODE_BACKWARD;
      else begin
        sp = first_space(w, 0, n);
        if (sp < n && sp > 0) begin
          if (same_word(w, 0, sp, "forward") || same_word(w, 0, sp, "f")) begin
            r.cmd = CODE_FORWARD;
            number_pair(w, sp + 1, n, r);
          end else if (same_word(w, 0, sp, "backward") || same_word(w, 0, sp, "b")) begin
            r.cmd = CODE_BACKWARD;
            number_pair(w, sp + 1, n, r);
          end else if (same_word(w, 0, sp, "turn")) begin
            r.cmd = CODE_TURN;
            r.num_a = atol_sat(w, sp + 1, n);
          end else if (same_word(w, 0, sp, "speed")) begin
            r.cmd = CODE_SPEED;
            r.num_a = atol_sat(w, sp + 1, n);
          end else if (same_word(w, 0, sp, "avoid")) begin
            r.cmd = CODE_AVOID;
            r.on = same_word(w, sp + 1, n, "on");
          end else if (same_word(w, 0, sp, "debug")) begin
            r.cmd = CODE_DEBUG;
            r.on = same_word(w, sp + 1, n, "on");
          end
        end
      end
      return r;
    endfunction

    // one accepted character
    function void note_char(byte unsigned c);
      if (c == CH_LF || c == CH_CR) begin
        if (line_q.size() == 0) return;
        pending_q.push_back(decode_line());
        line_q.delete();
      end else if (line_q.size() < LINE_MAX) begin
        line_q.push_back(c);
      end
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
    endfunction

    // one accepted result item
    function void check_result(logic [71:0] d);
      line_result_t x;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %0h", d);
        return;
      end
      x = pending_q.pop_front();
      if (d[3:0] != x.cmd) report("command_code", x.cmd, d[3:0]);
      if (d[35:4] != x.num_a) report("first_number", x.num_a, d[35:4]);
      if (d[67:36] != x.num_b) report("second_number", x.num_b, d[67:36]);
      if (d[68] != x.on) report("on_flag", x.on, d[68]);
      if (d[71:69] != 3'd0) report("pad", 0, d[71:69]);
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [71:0] m_axis_tdata_o;

  line_scoreboard sb = new();
  bit   quiet_phase;   // no idling near the end
  int   cycle_count;

  text_command_line_decoder_unit u_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("text_command_line_decoder_unit_tb: FAIL");
      $finish;
    end
  end

  // sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) sb.note_char(s_axis_tdata_i);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  // result side: ready stalls in random bursts
  initial begin
    int stall;
    forever begin
      @(negedge clk_i);
      if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 18);
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  // send one character; valid stays high back to back unless a gap is drawn
  task automatic send_char(byte unsigned c);
    int gap;
    if (!quiet_phase && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= c;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_line(string s, byte unsigned term);
    for (int k = 0; k < s.len(); k++) send_char(s[k]);
    send_char(term);
  endtask

  function automatic string rand_number();
    string s;
    int len;
    s = "";
    case ($urandom_range(0, 5))
      0: s = "-";
      1: s = "+";
      2: s = " ";
      default: ;
    endcase
    len = $urandom_range(0, 12);
    for (int k = 0; k < len; k++) s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
    if ($urandom_range(0, 5) == 0) s = {s, "x"};
    return s;
  endfunction

  function automatic string rand_case(string s);
    string r;
    r = s;
    for (int k = 0; k < r.len(); k++)
      if (r[k] >= "a" && r[k] <= "z" && $urandom_range(0, 3) == 0) r[k] = r[k] - 32;
    return r;
  endfunction

  function automatic string rand_command();
    string s;
    case ($urandom_range(0, 15))
      0: s = "help";  1: s = "ping";  2: s = "status"; 3: s = "distance";
      4: s = $urandom_range(0, 1) ? string'("stop") : string'("s");
      5: s = {$urandom_range(0, 1) ? string'("forward ") : string'("f "),
              rand_number(), " ", rand_number()};
      6: s = {$urandom_range(0, 1) ? string'("backward ") : string'("b "),
              rand_number(), " ", rand_number()};
      7: s = {$urandom_range(0, 1) ? string'("forward ") : string'("backward "),
              rand_number()};
      8: s = {"turn ", rand_number()};
      9: s = {"speed ", rand_number()};
      10: s = {"avoid ", $urandom_range(0, 1) ? string'("on") : string'("off")};
      11: s = {"debug ", $urandom_range(0, 2) ? string'("on") : string'("onn")};
      12: s = $urandom_range(0, 1) ? "f" : "b";
      13: s = {"stop ", rand_number()};
      default: begin
        // noise line with any byte but terminators
        s = "";
        for (int k = $urandom_range(1, 20); k > 0; k--) begin
          byte unsigned c;
          c = $urandom_range(0, 255);
          if (c == CH_LF || c == CH_CR) c = 8'h20;
          s = {s, string'(c)};
        end
      end
    endcase
    s = rand_case(s);
    if ($urandom_range(0, 3) == 0) s = {" \t", s};
    if ($urandom_range(0, 3) == 0) s = {s, "\t "};
    return s;
  endfunction

  int sent;
  bit paused;

  initial begin
    string long_line;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: every command, extremes, terminator on empty line,
    // blank line, known keyword with extra text, and buffer overflow
    send_char(CH_LF);
    send_line("help", CH_LF);
    send_line("  PING  ", CH_CR);
    send_line("status", CH_LF);
    send_line("distance", CH_LF);
    send_line("s", CH_CR);
    send_line("forward 99999999999 -99999999999", CH_LF);
    send_line("b -2147483648 2147483647", CH_LF);
    send_line("turn +45x", CH_LF);
    send_line("speed", CH_LF);
    send_line("avoid on", CH_LF);
    send_line("debug ON", CH_LF);
    send_line(" \t\v\f ", CH_LF);
    send_line("help x", CH_LF);
    send_char(8'h00); send_char(8'hFF); send_char(8'h80); send_char(CH_LF);
    long_line = "";
    for (int k = 0; k < 70; k++) long_line = {long_line, "a"};
    send_line(long_line, CH_CR);

    // random lines; part way through hold off once until every result is back
    sent = 0;
    while (sent < 1320) begin
      string s;
      if (!paused && sent > 600) begin
        paused = 1;
        s_axis_tvalid_i <= 1'b0;
        @(negedge clk_i);
        while (sb.pending_q.size() != 0) @(negedge clk_i);
      end
      if (sent > 1100) quiet_phase = 1;
      s = rand_command();
      if ($urandom_range(0, 20) == 0)
        for (int k = 0; k < 70; k++) s = {s, "9"};
      send_line(s, $urandom_range(0, 1) ? CH_LF : CH_CR);
      if ($urandom_range(0, 6) == 0) begin
        send_char(CH_CR);
        sent++;
      end
      sent += s.len() + 1;
    end
    s_axis_tvalid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (sb.mismatches == 0) begin
      $display("text_command_line_decoder_unit_tb: PASS");
    end else begin
      $display("text_command_line_decoder_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/tcld_pkg.sv
rtl/core/tcld_front.sv
rtl/core/tcld_queue.sv
rtl/core/tcld_back.sv
rtl/core/text_command_line_decoder_unit.sv
dv/text_command_line_decoder_unit_tb.sv
